>>> rtl/ssm_pkg.sv
// ----------------------------------------------------------------------------
// ssm_pkg: shared types and constants for the sorted set merge block
// Word formats, list sizing, opcode and mode codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package ssm_pkg;

  // list sizing
  localparam int LIST_DEPTH  = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
  localparam int ADDR_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  // input opcodes
  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_RUN    = 2'd2;

  // set_mode codes (unused code behaves as symmetric difference)
  localparam logic [1:0] MODE_UNION     = 2'd0;
  localparam logic [1:0] MODE_INTERSECT = 2'd1;
  localparam logic [1:0] MODE_SYMDIFF   = 2'd2;

  typedef struct packed {
    logic [1:0]                    opcode;
    logic signed [VALUE_WIDTH-1:0] element;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] result_value;
    logic                          last_flag;
    logic                          empty_flag;
    logic                          overflow_flag;
  } out_word_t;

  // compare unit result
  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CMP,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

>>> rtl/sorted_set_merge.sv
// ----------------------------------------------------------------------------
// sorted_set_merge: union / intersection / symmetric difference of two lists
// Loads two ascending lists and merges them with a two-pointer walk.
// ----------------------------------------------------------------------------
// A load word (opcode 0 or 1) is taken while busy stays low. A run word
// walks both lists through one compare unit; each walk step is a list RAM
// read (ST_FETCH), then compare and advance (ST_CMP), and busy stays high
// until ST_FINISH returns the sequencer to idle. Result words come
// out one per out_valid strobe, each for a single cycle, and the receiver
// cannot stall them; a result is held back one step so the final word can
// carry last_flag. An empty result yields one word with empty_flag set and
// value zero. Every run clears both lists and the overflow flag. set_mode is
// written through the cfg channel, which is always ready; write it only
// while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_set_merge (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // command channel
  input  wire logic               start,
  output logic                    busy,
  input  wire ssm_pkg::in_word_t  in_word,
  // result channel
  output logic                    out_valid,
  output ssm_pkg::out_word_t      out_word,
  // configuration channel
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_data
);
  import ssm_pkg::*;

  state_t                        state_r, state_nxt;
  logic [CNT_W-1:0]              i_r, i_nxt;
  logic [CNT_W-1:0]              j_r, j_nxt;
  logic [CNT_W-1:0]              a_cnt_r, a_cnt_nxt;
  logic [CNT_W-1:0]              b_cnt_r, b_cnt_nxt;
  logic                          dropped_r, dropped_nxt;
  logic [1:0]                    mode_r;
  logic                          pend_valid_r, pend_valid_nxt;
  logic signed [VALUE_WIDTH-1:0] pend_value_r, pend_value_nxt;
  logic                          out_valid_r, out_valid_nxt;
  out_word_t                     out_word_r, out_word_nxt;

  logic                          wr_a, wr_b;
  logic signed [VALUE_WIDTH-1:0] a_rd_data, b_rd_data;
  cmp_t                          cmp;
  logic                          a_live, b_live;
  logic                          keep_shared, keep_single;
  logic                          emit;
  logic signed [VALUE_WIDTH-1:0] emit_value;

  // list stores
  ssm_list_ram u_list_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (a_cnt_r[ADDR_W-1:0]),
    .wr_data (in_word.element),
    .rd_addr (i_r[ADDR_W-1:0]),
    .rd_data (a_rd_data)
  );

  ssm_list_ram u_list_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (b_cnt_r[ADDR_W-1:0]),
    .wr_data (in_word.element),
    .rd_addr (j_r[ADDR_W-1:0]),
    .rd_data (b_rd_data)
  );

  // shared compare unit
  ssm_compare u_compare (
    .a_val  (a_rd_data),
    .b_val  (b_rd_data),
    .result (cmp)
  );

  // mode decode
  assign keep_shared = (mode_r == MODE_UNION) || (mode_r == MODE_INTERSECT);
  assign keep_single = (mode_r != MODE_INTERSECT);
  assign a_live      = (i_r < a_cnt_r);
  assign b_live      = (j_r < b_cnt_r);

  // config register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_UNION;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_data;
    end
  end

  // sequencer: next state and datapath control
  always_comb begin
    state_nxt      = state_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    a_cnt_nxt      = a_cnt_r;
    b_cnt_nxt      = b_cnt_r;
    dropped_nxt    = dropped_r;
    pend_valid_nxt = pend_valid_r;
    pend_value_nxt = pend_value_r;
    out_valid_nxt  = 1'b0;
    out_word_nxt   = out_word_r;
    wr_a           = 1'b0;
    wr_b           = 1'b0;
    emit           = 1'b0;
    emit_value     = a_rd_data;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_word.opcode)
            OP_LOAD_A: begin
              if (a_cnt_r < CNT_W'(LIST_DEPTH)) begin
                wr_a      = 1'b1;
                a_cnt_nxt = a_cnt_r + CNT_W'(1);
              end else begin
                dropped_nxt = 1'b1;
              end
            end
            OP_LOAD_B: begin
              if (b_cnt_r < CNT_W'(LIST_DEPTH)) begin
                wr_b      = 1'b1;
                b_cnt_nxt = b_cnt_r + CNT_W'(1);
              end else begin
                dropped_nxt = 1'b1;
              end
            end
            OP_RUN: begin
              i_nxt          = '0;
              j_nxt          = '0;
              pend_valid_nxt = 1'b0;
              state_nxt      = ST_FETCH;
            end
            default: ;
          endcase
        end
      end

      // list heads are read at this edge
      ST_FETCH: begin
        if ((a_live && b_live) || (keep_single && (a_live || b_live))) begin
          state_nxt = ST_CMP;
        end else begin
          state_nxt = ST_FINISH;
        end
      end

      // one walk step
      ST_CMP: begin
        state_nxt = ST_FETCH;
        if (a_live && b_live) begin
          if (cmp.eq) begin
            emit       = keep_shared;
            emit_value = a_rd_data;
            i_nxt      = i_r + CNT_W'(1);
            j_nxt      = j_r + CNT_W'(1);
          end else if (cmp.gt) begin
            emit       = keep_single;
            emit_value = b_rd_data;
            j_nxt      = j_r + CNT_W'(1);
          end else begin
            emit       = keep_single;
            emit_value = a_rd_data;
            i_nxt      = i_r + CNT_W'(1);
          end
        end else if (a_live) begin
          emit       = 1'b1;
          emit_value = a_rd_data;
          i_nxt      = i_r + CNT_W'(1);
        end else begin
          emit       = 1'b1;
          emit_value = b_rd_data;
          j_nxt      = j_r + CNT_W'(1);
        end
      end

      // flush held word with last mark, or the empty word
      ST_FINISH: begin
        out_valid_nxt              = 1'b1;
        out_word_nxt.last_flag     = 1'b1;
        out_word_nxt.overflow_flag = dropped_r;
        if (pend_valid_r) begin
          out_word_nxt.result_value = pend_value_r;
          out_word_nxt.empty_flag   = 1'b0;
        end else begin
          out_word_nxt.result_value = '0;
          out_word_nxt.empty_flag   = 1'b1;
        end
        a_cnt_nxt   = '0;
        b_cnt_nxt   = '0;
        dropped_nxt = 1'b0;
        state_nxt   = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase

    // hold new word, release the previous one (not last)
    if (emit) begin
      if (pend_valid_r) begin
        out_valid_nxt              = 1'b1;
        out_word_nxt.result_value  = pend_value_r;
        out_word_nxt.last_flag     = 1'b0;
        out_word_nxt.empty_flag    = 1'b0;
        out_word_nxt.overflow_flag = dropped_r;
      end
      pend_valid_nxt = 1'b1;
      pend_value_nxt = emit_value;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      i_r          <= '0;
      j_r          <= '0;
      a_cnt_r      <= '0;
      b_cnt_r      <= '0;
      dropped_r    <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      i_r          <= i_nxt;
      j_r          <= j_nxt;
      a_cnt_r      <= a_cnt_nxt;
      b_cnt_r      <= b_cnt_nxt;
      dropped_r    <= dropped_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_value_r <= pend_value_nxt;
    out_word_r   <= out_word_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

>>> rtl/ssm_list_ram.sv
// ----------------------------------------------------------------------------
// ssm_list_ram: element store for one list
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ssm_list_ram (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [ssm_pkg::ADDR_W-1:0]             wr_addr,
  input  wire logic signed [ssm_pkg::VALUE_WIDTH-1:0] wr_data,
  input  wire logic [ssm_pkg::ADDR_W-1:0]             rd_addr,
  output logic signed [ssm_pkg::VALUE_WIDTH-1:0]      rd_data
);
  import ssm_pkg::*;

  logic signed [VALUE_WIDTH-1:0] mem [LIST_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> rtl/ssm_compare.sv
// ----------------------------------------------------------------------------
// ssm_compare: shared signed (two's complement) compare
// Compares the current heads of list A and list B.
// ----------------------------------------------------------------------------
`default_nettype none

module ssm_compare (
  input  wire logic signed [ssm_pkg::VALUE_WIDTH-1:0] a_val,
  input  wire logic signed [ssm_pkg::VALUE_WIDTH-1:0] b_val,
  output ssm_pkg::cmp_t                               result
);
  import ssm_pkg::*;

  always_comb begin
    result.eq = (a_val == b_val);
    result.gt = (a_val > b_val);
  end

endmodule

`default_nettype wire

>>> verif/merge_check_pkg.sv
// ----------------------------------------------------------------------------
// merge_check_pkg: result predictor and scoreboard for sorted_set_merge
// Mirrors both lists, the drop flag and set_mode, works out every result word
// that a run produces, and checks returned words in arrival order.
// ----------------------------------------------------------------------------
package merge_check_pkg;

  import ssm_pkg::*;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  localparam int MAX_REPORTS = 10;

  class merge_scoreboard;

    value_t      list_a [LIST_DEPTH];
    value_t      list_b [LIST_DEPTH];
    int unsigned count_a;
    int unsigned count_b;
    bit          load_dropped;
    logic [1:0]  mode;
    out_word_t   pending_results [$];
    int          error_count;

    function new();
      count_a      = 0;
      count_b      = 0;
      load_dropped = 1'b0;
      mode         = MODE_UNION;
      error_count  = 0;
    endfunction

    function void note_mode(logic [1:0] m);
      mode = m;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // one accepted command word
    function void note_input(in_word_t w);
      case (w.opcode)
        OP_LOAD_A: begin
          if (count_a < LIST_DEPTH) begin
            list_a[count_a] = w.element;
            count_a++;
          end else begin
            load_dropped = 1'b1;
          end
        end
        OP_LOAD_B: begin
          if (count_b < LIST_DEPTH) begin
            list_b[count_b] = w.element;
            count_b++;
          end else begin
            load_dropped = 1'b1;
          end
        end
        OP_RUN: merge_lists();
        default: ;  // unused opcode: word is ignored
      endcase
    endfunction

    function void push_result(value_t v);
      out_word_t w;
      w.result_value  = v;
      w.last_flag     = 1'b0;
      w.empty_flag    = 1'b0;
      w.overflow_flag = load_dropped;
      pending_results.push_back(w);
    endfunction

    // two-pointer walk over the stored lists, signed compare
    function void merge_lists();
      int unsigned i;
      int unsigned j;
      int          n;
      bit          keep_shared;
      bit          keep_single;
      out_word_t   w;
      i = 0;
      j = 0;
      n = 0;
      keep_shared = (mode == MODE_UNION) || (mode == MODE_INTERSECT);
      keep_single = (mode != MODE_INTERSECT);
      while (i < count_a && j < count_b) begin
        if (list_a[i] == list_b[j]) begin
          if (keep_shared) begin
            push_result(list_a[i]);
            n++;
          end
          i++;
          j++;
        end else if (list_a[i] > list_b[j]) begin
          if (keep_single) begin
            push_result(list_b[j]);
            n++;
          end
          j++;
        end else begin
          if (keep_single) begin
            push_result(list_a[i]);
            n++;
          end
          i++;
        end
      end
      // tails only matter when single elements are kept
      if (keep_single) begin
        for (; i < count_a; i++) begin
          push_result(list_a[i]);
          n++;
        end
        for (; j < count_b; j++) begin
          push_result(list_b[j]);
          n++;
        end
      end
      // nothing to emit: one zero word flagged empty
      if (n == 0) begin
        push_result('0);
        w = pending_results.pop_back();
        w.empty_flag = 1'b1;
        pending_results.push_back(w);
      end
      w = pending_results.pop_back();
      w.last_flag = 1'b1;
      pending_results.push_back(w);
      count_a      = 0;
      count_b      = 0;
      load_dropped = 1'b0;
    endfunction

    function void report(string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("%s", msg);
    endfunction

    // one result word off the strobe, compared with the oldest prediction
    function void check_result(out_word_t got);
      out_word_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result word: value %0d last %b empty %b overflow %b",
                         got.result_value, got.last_flag, got.empty_flag,
                         got.overflow_flag));
        return;
      end
      want = pending_results.pop_front();
      if (got.result_value !== want.result_value || got.last_flag !== want.last_flag ||
          got.empty_flag !== want.empty_flag || got.overflow_flag !== want.overflow_flag)
        report($sformatf({"result mismatch: expected value %0d last %b empty %b ",
                          "overflow %b, got value %0d last %b empty %b overflow %b"},
                         want.result_value, want.last_flag, want.empty_flag,
                         want.overflow_flag, got.result_value, got.last_flag,
                         got.empty_flag, got.overflow_flag));
    endfunction

  endclass

endpackage

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for sorted_set_merge
// Loads pairs of lists, runs merges in every set_mode and compares each
// result word against a predictor; covers extremes, full lists, empty results,
// unused codes, unsorted lists and random sender gaps.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import ssm_pkg::*;
  import merge_check_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 11;
  localparam int RANDOM_ITEMS  = 280;
  // longest run walk plus margin
  localparam int SETTLE_CYCLES = 2 * (2 * LIST_DEPTH) + 8;
  localparam int CYCLE_LIMIT   = 400000;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam longint VALUE_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint VALUE_MIN = -64'sh0000_0000_8000_0000;

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       start     = 1'b0;
  logic       busy;
  in_word_t   in_word   = '0;
  logic       out_valid;
  out_word_t  out_word;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_data  = '0;

  merge_scoreboard sb = new();

  int burst_left  = 0;
  int items_sent  = 0;
  int cycle_count = 0;

  sorted_set_merge u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // result monitor: one word per strobe, no back-pressure
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_word);
  end

  function automatic in_word_t make_word(logic [1:0] op, value_t v);
    in_word_t w;
    w.opcode  = op;
    w.element = v;
    return w;
  endfunction

  // hold start until the block takes the word
  task automatic drive_word(input in_word_t w);
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_input(w);
  endtask

  // bursty sender: random gaps between bursts of random length
  task automatic send_word(input in_word_t w);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
    drive_word(w);
    if (w.opcode != OP_UNUSED) items_sent++;
  endtask

  task automatic wait_results();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // idle the block: all results in, then let a run's tail finish
  task automatic drain_block();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.note_mode(m);
    cfg_valid <= 1'b0;
  endtask

  // extremes, unused opcode, ignored run element, full list, empty results
  task automatic run_directed();
    int k;
    // empty lists under the reset mode
    send_word(make_word(OP_RUN, 32'sh1234_5678));
    // union with signed extremes and shared values
    send_word(make_word(OP_LOAD_A, value_t'(VALUE_MIN)));
    send_word(make_word(OP_LOAD_B, -32'sd1));
    send_word(make_word(OP_LOAD_A, -32'sd1));
    send_word(make_word(OP_LOAD_B, 32'sd0));
    send_word(make_word(OP_UNUSED, 32'shFFFF_FFFF));
    send_word(make_word(OP_LOAD_A, value_t'(VALUE_MAX)));
    send_word(make_word(OP_LOAD_B, value_t'(VALUE_MAX)));
    send_word(make_word(OP_RUN, 32'shDEAD_BEEF));
    drain_block();
    // full list A, intersection with empty B: empty word with overflow
    write_mode(MODE_INTERSECT);
    for (k = 0; k <= LIST_DEPTH; k++)
      send_word(make_word(OP_LOAD_A, value_t'(k * 1000 - 8000)));
    send_word(make_word(OP_RUN, '0));
  endtask

  // one random list pair followed by a run
  task automatic run_random_set();
    value_t   vals_a [$];
    value_t   vals_b [$];
    longint   cur;
    int       kind;
    int       cap;
    int       m;
    int       k;
    int       pick;
    int       noise_odds;
    bit       big_steps;
    bit       from_a;
    kind       = $urandom_range(0, 9);
    cap        = (kind == 6) ? LIST_DEPTH + 3 : LIST_DEPTH;
    noise_odds = (kind == 9) ? 3 : 30;
    if (kind == 7 || kind == 8) begin
      // broken lists: unsorted words or many duplicates
      m = $urandom_range(0, 8);
      repeat (m) vals_a.push_back((kind == 7) ? value_t'($urandom)
                                              : value_t'($urandom_range(0, 5)) - 2);
      m = $urandom_range(0, 8);
      repeat (m) vals_b.push_back((kind == 7) ? value_t'($urandom)
                                              : value_t'($urandom_range(0, 5)) - 2);
    end else begin
      // ascending walk, each value lands in A, B or both
      case ($urandom_range(0, 3))
        0:       cur = VALUE_MIN + $urandom_range(0, 3);
        1:       cur = VALUE_MAX - $urandom_range(0, 40);
        2:       cur = longint'(int'($urandom));
        default: cur = -longint'($urandom_range(0, 20));
      endcase
      big_steps = ($urandom_range(0, 2) == 0);
      if (kind == 6)
        m = $urandom_range(LIST_DEPTH + 1, 2 * LIST_DEPTH + 6);
      else
        m = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2 * LIST_DEPTH)
                                        : $urandom_range(0, 10);
      for (k = 0; k < m && cur <= VALUE_MAX; k++) begin
        pick = $urandom_range(0, 2);
        if (pick != 1 && vals_a.size() < cap) vals_a.push_back(value_t'(cur));
        if (pick != 0 && vals_b.size() < cap) vals_b.push_back(value_t'(cur));
        cur += big_steps ? longint'($urandom_range(1, 1 << 28))
                         : longint'($urandom_range(1, 3));
      end
    end
    // interleave loads, keeping order within each list
    while (vals_a.size() + vals_b.size() > 0) begin
      if ($urandom_range(1, noise_odds) == 1)
        send_word(make_word(OP_UNUSED, value_t'($urandom)));
      from_a = (vals_b.size() == 0) || (vals_a.size() != 0 && $urandom_range(0, 1) == 1);
      if (from_a)
        send_word(make_word(OP_LOAD_A, vals_a.pop_front()));
      else
        send_word(make_word(OP_LOAD_B, vals_b.pop_front()));
    end
    send_word(make_word(OP_RUN, value_t'($urandom)));
    // sometimes hold off until the run has fully drained
    if ($urandom_range(0, 9) == 0) wait_results();
  endtask

  // main sequence
  initial begin
    int         phase;
    int         sets_left;
    logic [1:0] next_mode;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    items_sent = 0;
    phase      = 0;
    while (items_sent < RANDOM_ITEMS) begin
      case (phase)
        0:       next_mode = MODE_SYMDIFF;
        1:       next_mode = MODE_UNUSED;
        2:       next_mode = MODE_UNION;
        3:       next_mode = MODE_INTERSECT;
        default: next_mode = 2'($urandom_range(0, 3));
      endcase
      drain_block();
      write_mode(next_mode);
      sets_left = $urandom_range(3, 6);
      while (sets_left > 0 && items_sent < RANDOM_ITEMS) begin
        run_random_set();
        sets_left--;
      end
      phase++;
    end
    drain_block();
    if (sb.error_count == 0 && sb.pending() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
